@@ design/alpl_pkg.sv @@
package alpl_pkg;

    // field widths
    localparam int INDEX_W   = 10;
    localparam int LENGTH_W  = 31;
    localparam int DIST_W    = 32;
    localparam int CURSOR_W  = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 31;

    // request kinds on the input channel
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPLINE_LENGTH = 2'd1;

    // configuration reset values
    localparam logic [INDEX_W-1:0]  SAMPLE_COUNT_RST  = 10'd1023;
    localparam logic [LENGTH_W-1:0] SPLINE_LENGTH_RST = 31'd0;

    // classified command kinds
    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_END,
        CMD_ZERO,
        CMD_SCAN
    } cmd_kind_t;

    // command passed from front to back
    typedef struct packed {
        cmd_kind_t            kind;
        logic [INDEX_W-1:0]   index;
        logic [LENGTH_W-1:0]  data;
    } cmd_t;

    // configuration seen by front and back
    typedef struct packed {
        logic [INDEX_W-1:0]   sample_count;
        logic [LENGTH_W-1:0]  spline_length;
    } cfg_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } state_t;

endpackage

@@ design/arc_length_to_parameter_lookup.sv @@
// Arc-length to parameter lookup.
// Input channel (push/full): one item per accepted push. req_type 0 loads
// entry_value into table slot entry_index (slots beyond the table are dropped,
// slot 0 also restarts the search cursor). req_type 1 converts query_distance
// into a sample index; t = sample_index / sample_count.
// Result channel (empty/pop): one item per query, oldest first, held until
// popped. Configuration (cfg_valid/cfg_ready, always ready): index 0 is
// sample_count, index 1 is spline_length; other indexes are ignored.
// Timing: a two-item queue separates the classifier from the table engine.
// Loads are written to the table from the idle state. Queries that clamp to
// the start or the end are answered from the idle state without a table
// read, once the result register is free. Scanned queries pass through
// ST_READ and ST_CHECK, one table read and compare per entry examined, and
// finish from ST_READ when the scan runs off the table.
// A full result register holds the engine when it has a result to write;
// the queue then fills and raises full. Reset empties the command queue and
// the result register, clears cursor and last distance and loads the
// configuration defaults; table contents are undefined until loaded.
module arc_length_to_parameter_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            req_type,
    input  logic [alpl_pkg::INDEX_W-1:0]    entry_index,
    input  logic [alpl_pkg::LENGTH_W-1:0]   entry_value,
    input  logic signed [alpl_pkg::DIST_W-1:0] query_distance,
    output logic                            empty,
    input  logic                            pop,
    output logic [alpl_pkg::INDEX_W-1:0]    sample_index,
    output logic                            reached_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [alpl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [alpl_pkg::CFG_DAT_W-1:0]  cfg_data
);

    import alpl_pkg::*;

    logic [INDEX_W-1:0]  sample_count_reg;
    logic [LENGTH_W-1:0] spline_length_reg;
    cfg_t                cfg;
    logic                q_valid;
    cmd_t                q_cmd;
    logic                q_pop;
    logic                res_valid;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg  <= SAMPLE_COUNT_RST;
            spline_length_reg <= SPLINE_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SAMPLE_COUNT:  sample_count_reg  <= cfg_data[INDEX_W-1:0];
                REG_SPLINE_LENGTH: spline_length_reg <= cfg_data[LENGTH_W-1:0];
                default:           sample_count_reg  <= sample_count_reg;
            endcase
        end
    end

    assign cfg.sample_count  = sample_count_reg;
    assign cfg.spline_length = spline_length_reg;

    // classifier and command queue
    alpl_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .entry_index    (entry_index),
        .entry_value    (entry_value),
        .query_distance (query_distance),
        .cfg            (cfg),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop)
    );

    // table engine and result register
    alpl_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_index (sample_index),
        .res_end   (reached_end),
        .res_pop   (pop)
    );

    assign empty = !res_valid;

    // engine never takes a command from an empty queue
    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command taken from empty queue");

    // end results always carry sample_count
    a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && reached_end) |-> (sample_index == sample_count_reg))
        else $error("end result with wrong index");

    // a full queue always offers a command to the engine
    a_full_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_valid)
        else $error("queue full but no command offered");

endmodule

@@ design/alpl_ram.sv @@
module alpl_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds while not read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/alpl_front.sv @@
module alpl_front #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          req_type,
    input  logic [alpl_pkg::INDEX_W-1:0]  entry_index,
    input  logic [alpl_pkg::LENGTH_W-1:0] entry_value,
    input  logic signed [alpl_pkg::DIST_W-1:0] query_distance,
    input  alpl_pkg::cfg_t                cfg,
    output logic                          q_valid,
    output alpl_pkg::cmd_t                q_cmd,
    input  logic                          q_pop
);

    import alpl_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    cmd_t        cmd_in;
    logic        in_range;
    logic        is_end;
    logic        is_zero;
    logic        accept;
    logic        q_write;
    logic [31:0] index_wide;

    // classify the incoming item
    assign index_wide = 32'(entry_index);
    assign in_range   = index_wide < 32'(TABLE_DEPTH);
    assign is_end     = query_distance >= $signed({1'b0, cfg.spline_length});
    assign is_zero    = query_distance[DIST_W-1] || (query_distance == '0);

    always_comb
    begin
        cmd_in.index = entry_index;
        cmd_in.data  = entry_value;
        if (req_type == REQ_LOAD)
        begin
            cmd_in.kind = CMD_LOAD;
        end
        else if (is_end)
        begin
            cmd_in.kind = CMD_END;
        end
        else if (is_zero)
        begin
            cmd_in.kind = CMD_ZERO;
        end
        else
        begin
            cmd_in.kind = CMD_SCAN;
            cmd_in.data = query_distance[LENGTH_W-1:0];
        end
    end

    // loads beyond the table are taken and dropped
    assign full    = count_reg == 2'd2;
    assign accept  = push && !full;
    assign q_write = accept && !(req_type == REQ_LOAD && !in_range);
    assign q_valid = count_reg != 2'd0;
    assign q_cmd   = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ q_write;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg;
        if (q_write && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!q_write && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (q_write)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ design/alpl_back.sv @@
module alpl_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  alpl_pkg::cfg_t               cfg,
    input  logic                         q_valid,
    input  alpl_pkg::cmd_t               q_cmd,
    output logic                         q_pop,
    output logic                         res_valid,
    output logic [alpl_pkg::INDEX_W-1:0] res_index,
    output logic                         res_end,
    input  logic                         res_pop
);

    import alpl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    state_t              state_reg, state_next;
    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [LENGTH_W-1:0] last_reg, last_next;
    logic [CURSOR_W-1:0] cur_reg, cur_next;
    logic [LENGTH_W-1:0] dist_reg, dist_next;
    logic                res_valid_reg, res_valid_next;
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;
    logic                res_end_reg, res_end_next;

    logic                res_free;
    logic                beyond;
    logic                hit;
    logic [CURSOR_W-1:0] start_cur;
    logic [CURSOR_W-1:0] abs_idx;
    logic [31:0]         cur_wide;
    logic [31:0]         load_wide;
    logic                ram_we;
    logic                ram_re;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [LENGTH_W-1:0] ram_rdata;

    // length table
    alpl_ram #(
        .WIDTH (LENGTH_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (q_cmd.data),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // address forming and scan conditions
    assign load_wide = 32'(q_cmd.index);
    assign cur_wide  = 32'(cur_reg);
    assign ram_waddr = load_wide[AW-1:0];
    assign ram_raddr = cur_wide[AW-1:0];
    assign res_free  = !res_valid_reg || res_pop;
    assign beyond    = (cur_reg > {1'b0, cfg.sample_count}) || (cur_wide >= 32'(TABLE_DEPTH));
    assign hit       = ram_rdata >= dist_reg;
    assign abs_idx   = (cur_reg >= 11'd2) ? (cur_reg - 11'd2) : (11'd2 - cur_reg);

    // starting position: one back, or from zero when the distance shrank
    always_comb
    begin
        start_cur = (cursor_reg == '0) ? '0 : cursor_reg - 11'd1;
        if (q_cmd.data < last_reg)
        begin
            start_cur = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_cmd.kind == CMD_SCAN)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!beyond)
                begin
                    state_next = ST_CHECK;
                end
                else if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (!hit)
                begin
                    state_next = ST_READ;
                end
                else if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and handshake outputs
    always_comb
    begin
        cursor_next    = cursor_reg;
        last_next      = last_reg;
        cur_next       = cur_reg;
        dist_next      = dist_reg;
        res_valid_next = res_valid_reg && !res_pop;
        res_index_next = res_index_reg;
        res_end_next   = res_end_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.kind)
                        CMD_LOAD:
                        begin
                            q_pop  = 1'b1;
                            ram_we = 1'b1;
                            if (q_cmd.index == '0)
                            begin
                                cursor_next = '0;
                                last_next   = '0;
                            end
                        end
                        CMD_END:
                        begin
                            if (res_free)
                            begin
                                q_pop          = 1'b1;
                                res_valid_next = 1'b1;
                                res_index_next = cfg.sample_count;
                                res_end_next   = 1'b1;
                            end
                        end
                        CMD_ZERO:
                        begin
                            if (res_free)
                            begin
                                q_pop          = 1'b1;
                                res_valid_next = 1'b1;
                                res_index_next = '0;
                                res_end_next   = 1'b0;
                            end
                        end
                        default:
                        begin
                            q_pop     = 1'b1;
                            cur_next  = start_cur;
                            last_next = q_cmd.data;
                            dist_next = q_cmd.data;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (!beyond)
                begin
                    ram_re   = 1'b1;
                    cur_next = cur_reg + 11'd1;
                end
                else if (res_free)
                begin
                    cursor_next    = cur_reg;
                    res_valid_next = 1'b1;
                    res_index_next = cfg.sample_count;
                    res_end_next   = 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (hit && res_free)
                begin
                    cursor_next    = cur_reg;
                    res_valid_next = 1'b1;
                    res_index_next = abs_idx[INDEX_W-1:0];
                    res_end_next   = 1'b0;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            last_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        dist_reg      <= dist_next;
        res_index_reg <= res_index_next;
        res_end_reg   <= res_end_next;
    end

    assign res_valid = res_valid_reg;
    assign res_index = res_index_reg;
    assign res_end   = res_end_reg;

endmodule

@@ test/tb.sv @@
module tb;
    import alpl_pkg::*;

    localparam int     TABLE_DEPTH    = 1024;
    localparam int     PERIOD         = 10;
    localparam int     RESET_CYCLES   = 12;
    localparam int     RANDOM_ITEMS   = 900;
    localparam int     SETTLE_CYCLES  = 24;
    localparam int     WATCHDOG_LIMIT = 20000;
    localparam longint MAX_LEN        = 64'h7FFF_FFFF;

    // register indexes the block does not implement
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [INDEX_W-1:0] sample_index;
        logic               reached_end;
    } param_t;

    // table copy, cursor, registers and the parameters still owed
    class param_tracker;
        logic [LENGTH_W-1:0] lengths [TABLE_DEPTH];
        bit                  loaded [TABLE_DEPTH];
        int unsigned         cursor = 0;
        int                  prev_dist = 0;
        logic [INDEX_W-1:0]  count = SAMPLE_COUNT_RST;
        logic [LENGTH_W-1:0] span_len = SPLINE_LENGTH_RST;
        param_t              due_params [$];
        int                  errors = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == REG_SAMPLE_COUNT)
                count = data[INDEX_W-1:0];
            else if (idx == REG_SPLINE_LENGTH)
                span_len = data[LENGTH_W-1:0];
        endfunction

        // distance to sample index; state only moves when commit is set
        function param_t resolve_distance(input int qdist, input bit commit,
                                          output bit unsafe);
            param_t      res;
            int unsigned pos;
            longint      reached;
            unsafe = 1'b0;
            res.sample_index = count;
            res.reached_end  = 1'b1;
            if (longint'(qdist) >= longint'(span_len))
                return res;
            res.sample_index = '0;
            res.reached_end  = 1'b0;
            if (qdist <= 0)
                return res;
            pos = cursor;
            if (pos > 0)
                pos--;
            if (qdist < prev_dist)
                pos = 0;
            if (commit)
                prev_dist = qdist;
            reached = 0;
            while (reached < longint'(qdist))
            begin
                if (pos > count || pos >= TABLE_DEPTH)
                begin
                    res.sample_index = count;
                    res.reached_end  = 1'b1;
                    break;
                end
                if (!loaded[pos])
                    unsafe = 1'b1;
                reached = lengths[pos];
                pos++;
            end
            if (commit)
                cursor = pos;
            if (!res.reached_end)
                res.sample_index = INDEX_W'((pos >= 2) ? pos - 2 : 2 - pos);
            return res;
        endfunction

        function void note_item(logic rt, logic [INDEX_W-1:0] ei,
                                logic [LENGTH_W-1:0] ev, logic [DIST_W-1:0] qd);
            bit unused;
            if (rt == REQ_LOAD)
            begin
                lengths[ei] = ev;
                loaded[ei]  = 1'b1;
                if (ei == 0)
                begin
                    cursor    = 0;
                    prev_dist = 0;
                end
            end
            else
                due_params.push_back(resolve_distance(int'(qd), 1'b1, unused));
        endfunction

        function void check_result(logic [INDEX_W-1:0] si, logic re);
            param_t want;
            if (due_params.size() == 0)
            begin
                $error("unexpected item: sample_index %0d reached_end %0d", si, re);
                errors++;
                return;
            end
            want = due_params.pop_front();
            if (si !== want.sample_index)
            begin
                $error("sample_index expected %0d actual %0d", want.sample_index, si);
                errors++;
            end
            if (re !== want.reached_end)
            begin
                $error("reached_end expected %0d actual %0d", want.reached_end, re);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic                       req_type;
    logic [INDEX_W-1:0]         entry_index;
    logic [LENGTH_W-1:0]        entry_value;
    logic signed [DIST_W-1:0]   query_distance;
    logic                       empty;
    logic                       pop;
    logic [INDEX_W-1:0]         sample_index;
    logic                       reached_end;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DAT_W-1:0]       cfg_data;

    param_tracker board;
    int           sent = 0;
    int           burst_left = 0;
    int           quiet = 0;
    int           stall_run = 0;
    int           pop_pct = 100;

    arc_length_to_parameter_lookup #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .entry_index   (entry_index),
        .entry_value   (entry_value),
        .query_distance(query_distance),
        .empty         (empty),
        .pop           (pop),
        .sample_index  (sample_index),
        .reached_end   (reached_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always #(PERIOD / 2) clk = ~clk;

    // result side stalls in runs of random length and rate
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_run = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       pop_pct = 100;
                1:       pop_pct = 75;
                2:       pop_pct = 40;
                default: pop_pct = 10;
            endcase
        end
        stall_run--;
        pop = ($urandom_range(0, 99) < pop_pct);
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                board.check_result(sample_index, reached_end);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // one item on the input side, sent in bursts with random gaps
    task automatic push_item(input logic rt, input logic [INDEX_W-1:0] ei,
                             input logic [LENGTH_W-1:0] ev, input logic [DIST_W-1:0] qd);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                push = 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        push           = 1'b1;
        req_type       = rt;
        entry_index    = ei;
        entry_value    = ev;
        query_distance = qd;
        do @(posedge clk); while (full);
        board.note_item(rt, ei, ev, qd);
        sent++;
    endtask

    task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [LENGTH_W-1:0] val);
        push_item(REQ_LOAD, idx, val, $urandom);
    endtask

    // a scan that would read a never loaded entry is turned into a zero query
    task automatic send_query(input int qdist);
        bit unsafe;
        void'(board.resolve_distance(qdist, 1'b0, unsafe));
        if (unsafe)
            qdist = 0;
        push_item(REQ_QUERY, INDEX_W'($urandom), LENGTH_W'($urandom), qdist);
    endtask

    // drain all results and let trailing loads finish
    task automatic settle();
        @(negedge clk);
        push = 1'b0;
        while (board.due_params.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // configure, fill entries 0..fill with a non-decreasing table, then query it
    task automatic run_phase(input int count_cfg, input int fill, input longint top,
                             input bit long_tail);
        logic [LENGTH_W-1:0]  vals [TABLE_DEPTH];
        logic [CFG_DAT_W-1:0] word;
        longint               acc, avg, last, spline, walk, d, stepmax;
        int                   nq, sel;
        settle();
        word = $urandom;
        word[INDEX_W-1:0] = INDEX_W'(count_cfg);
        write_reg(REG_SAMPLE_COUNT, word);

        // cumulative lengths, sometimes starting above zero
        avg = top / (fill + 1);
        acc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, avg) : 0;
        for (int i = 0; i <= fill; i++)
        begin
            vals[i] = LENGTH_W'(acc);
            acc += $urandom_range(0, 2 * avg);
            if (acc > MAX_LEN)
                acc = MAX_LEN;
        end
        last = vals[fill];

        // path length at, above or below the last entry
        sel = $urandom_range(0, 99);
        if ((long_tail || sel < 15) && last < MAX_LEN)
            spline = last + 1 + $urandom_range(0, MAX_LEN - last - 1);
        else if (sel < 25)
            spline = $urandom_range(0, last);
        else if (sel < 28)
            spline = 0;
        else
            spline = last;
        write_reg(REG_SPLINE_LENGTH, CFG_DAT_W'(spline));
        if ($urandom_range(0, 9) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                      CFG_DAT_W'($urandom));

        for (int i = 0; i <= fill; i++)
            send_load(INDEX_W'(i), vals[i]);

        nq = $urandom_range(fill / 2 + 6, 2 * fill + 24);
        if (nq > 80)
            nq = 80;
        stepmax = (last / (fill + 1)) * 3 + 1;
        if (stepmax > MAX_LEN)
            stepmax = MAX_LEN;
        walk = 0;
        for (int q = 0; q < nq; q++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                // forward walk, a few entries per query
                walk += $urandom_range(1, stepmax);
                if (walk > last)
                    walk = $urandom_range(1, stepmax);
                send_query(int'(walk));
            end
            else if (sel < 63)
                send_query(int'(walk - $urandom_range(0, stepmax)));
            else if (sel < 70)
            begin
                d = longint'(vals[$urandom_range(0, fill)]) + $urandom_range(0, 2) - 1;
                send_query(int'(d));
            end
            else if (sel < 75)
            begin
                case ($urandom_range(0, 3))
                    0:       d = 0;
                    1:       d = -1;
                    2:       d = -64'sd2147483648;
                    default: d = -longint'($urandom_range(1, MAX_LEN));
                endcase
                send_query(int'(d));
            end
            else if (sel < 80)
                send_query($urandom_range(0, 1) ? int'(MAX_LEN) : int'(spline + $urandom_range(0, 3)));
            else if (sel < 84)
            begin
                // between the last entry and the path length: the table runs out
                if (spline > last + 1)
                    d = last + 1 + $urandom_range(0, spline - last - 2);
                else
                    d = $urandom_range(1, stepmax);
                send_query(int'(d));
            end
            else if (sel < 88)
                send_query($urandom);
            else if (sel < 93)
            begin
                // reload entry zero, which restarts the search
                send_load(0, board.lengths[0]);
                walk = 0;
            end
            else if (sel < 96)
                send_load(INDEX_W'($urandom), LENGTH_W'($urandom));
            else
                send_query(int'(walk));
        end
    endtask

    initial
    begin
        int     n, fill, sel, start;
        longint top;
        board          = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        req_type       = REQ_LOAD;
        entry_index    = '0;
        entry_value    = '0;
        query_distance = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_SAMPLE_COUNT;
        cfg_data       = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers: zero path length puts distance zero at the end
        send_query(0);
        send_query(32'sh8000_0000);
        send_query(32'sh7FFF_FFFF);
        send_load(0, 31'd5);
        send_load(1, 31'd10);
        send_load(2, 31'd20);
        send_load(3, 31'd40);
        send_load(4, 31'h7FFF_FFFF);
        settle();
        write_reg(REG_SAMPLE_COUNT, 31'h7FFF_FC04);
        write_reg(REG_SPLINE_LENGTH, 31'h7FFF_FFFF);

        // first entry already covers it, exact hits, shrinking distance
        send_query(3);
        send_query(10);
        send_query(15);
        send_query(2);
        send_query(32'sh7FFF_FFFE);
        send_query(32'sh7FFF_FFFF);
        send_query(-1);
        send_query(0);
        send_load(0, 31'd5);
        send_query(40);
        settle();

        // table runs out before the path length
        write_reg(REG_SAMPLE_COUNT, 31'd2);
        send_query(50);
        send_query(30);
        settle();

        // zero sample count, and writes to unused indexes
        write_reg(REG_SAMPLE_COUNT, 31'h7FFF_FC00);
        write_reg(REG_SPARE_LO, CFG_DAT_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DAT_W'($urandom));
        send_query(3);
        send_query(50);
        send_query(5);

        // random phases, mostly small tables
        start = sent;
        while (sent - start < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                n    = $urandom_range(1, 24);
                fill = n;
            end
            else if (sel < 85)
            begin
                n    = $urandom_range(25, 120);
                fill = n;
            end
            else if (sel < 92)
            begin
                n    = 0;
                fill = 0;
            end
            else
            begin
                n    = TABLE_DEPTH - 1;
                fill = $urandom_range(1, 30);
            end
            sel = $urandom_range(0, 9);
            if (sel < 4)
                top = fill * 4 + $urandom_range(1, 50);
            else if (sel < 8)
                top = $urandom_range(1, 1 << 20);
            else
                top = MAX_LEN;
            run_phase(n, fill, top, $urandom_range(0, 9) == 0);
        end

        settle();
        if (board.errors == 0 && board.due_params.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
design/alpl_pkg.sv
design/alpl_ram.sv
design/alpl_front.sv
design/alpl_back.sv
design/arc_length_to_parameter_lookup.sv
test/tb.sv
